// ----- hdl/smf_pkg.sv -----
// smf_pkg: shared types and constants for the sliding median filter
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package smf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int HIST_DEPTH  = 4;
	localparam int TAPS_MAX    = HIST_DEPTH + 1;
	localparam int PADDR_BITS  = 3;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [2:0]             held_t;
	typedef logic [1:0]             beat_cnt_t;

	localparam held_t HELD_MAX = 3'd4;

	typedef enum logic {
		MODE_FIVE  = 1'b0,
		MODE_THREE = 1'b1
	} win_mode_t;

	// register index taken from paddr[2]
	localparam logic REG_WINDOW_MODE = 1'b0;

	// input register contents: current sample in win[0], older ones behind it
	typedef struct packed {
		sample_t [TAPS_MAX-1:0] win;
		held_t                  held;
		win_mode_t              mode;
		logic                   last;
	} s1_t;

endpackage

// ----- hdl/smf_in_if.sv -----
// smf_in_if: sample channel, valid/ready with the input beat payload
// depends on smf_pkg
`timescale 1ns / 1ps

interface smf_in_if;
	logic              valid;
	logic              ready;
	smf_pkg::sample_t  sample_in;
	logic              last_sample;

	modport source (output valid, output sample_in, output last_sample, input ready);
	modport sink   (input valid, input sample_in, input last_sample, output ready);
endinterface

// ----- hdl/smf_out_if.sv -----
// smf_out_if: result channel, valid/ready with the result beat payload
// depends on smf_pkg
`timescale 1ns / 1ps

interface smf_out_if;
	logic              valid;
	logic              ready;
	smf_pkg::sample_t  filtered_value;
	logic              edge_fill;
	logic              last_of_run;
	logic              end_of_stream;

	modport source (output valid, output filtered_value, output edge_fill,
		output last_of_run, output end_of_stream, input ready);
	modport sink   (input valid, input filtered_value, input edge_fill,
		input last_of_run, input end_of_stream, output ready);
endinterface

// ----- hdl/sliding_median_filter.sv -----
// sliding_median_filter: top level, apb mode register, front, median network, emit
// depends on smf_pkg, smf_in_if, smf_out_if, smf_front, smf_median, smf_emit
`timescale 1ns / 1ps

// channel    | dir | payload                                          | beats
// -----------+-----+--------------------------------------------------+--------------------
// sample_ch  | in  | sample_in[15:0], last_sample                     | one per sample
// result_ch  | out | filtered_value[15:0], edge_fill, last_of_run,    | 0..3 per sample
//            |     | end_of_stream                                    |
// apb        | in  | window_mode at byte address 0                    | setup + access
//
// a sample enters the input register, the median network settles from it and the result
// register loads once it is empty or its last beat is taken; one sample per cycle
// sustained mid-stream while result_ch is ready; the last sample of a stream costs
// up to three result beats, set by the single result register draining one per ready cycle
// arst_n clears the window history, position count, valid flags and window_mode
// a stalled result holds in the result register while one more sample waits in
// the input register; sample_ch.ready drops only once both are occupied

module sliding_median_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smf_pkg::PADDR_BITS-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	smf_in_if.sink                               sample_ch,
	smf_out_if.source                            result_ch
);

	smf_pkg::win_mode_t mode_q;
	logic               cfg_write;
	logic               s1_valid;
	smf_pkg::s1_t       s1;
	smf_pkg::sample_t   median;
	logic               take;

	// apb: always ready, write lands on the access cycle
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= smf_pkg::MODE_FIVE;
		end else if (cfg_write && paddr[2] == smf_pkg::REG_WINDOW_MODE) begin
			mode_q <= smf_pkg::win_mode_t'(pwdata[0]);
		end
	end

	// unknown register addresses read as zero
	assign prdata = (paddr[2] == smf_pkg::REG_WINDOW_MODE) ? {31'd0, mode_q} : 32'd0;

	// history shift and input register
	smf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.sample_ch (sample_ch),
		.take      (take),
		.s1_valid  (s1_valid),
		.s1        (s1)
	);

	// combinational median straight off the input register
	smf_median u_median (
		.s1     (s1),
		.median (median)
	);

	// result register and edge-zero flush sequencing
	smf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.median    (median),
		.take      (take),
		.result_ch (result_ch)
	);

`ifndef SYNTHESIS
	// a true median is never the final beat of a stream: flush zeros always follow it
	a_median_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.edge_fill |-> !result_ch.end_of_stream)
		else $error("true median flagged as end of stream");

	// edge beats carry a zero value
	a_edge_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.edge_fill |-> result_ch.filtered_value == '0)
		else $error("edge beat with nonzero value");

	// the end of a stream also closes the run of its last sample
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.end_of_stream |-> result_ch.last_of_run)
		else $error("end of stream without last of run");

	// input register may only be refilled when it is being drained or empty
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !take |-> !sample_ch.ready)
		else $error("sample accepted over a held item");
`endif

endmodule

// ----- hdl/smf_median.sv -----
// smf_median: rank-count median network over a 5- or 3-tap window
// depends on smf_pkg
`timescale 1ns / 1ps

module smf_median (
	input  smf_pkg::s1_t    s1,
	output smf_pkg::sample_t median
);

	always_comb begin
		logic [smf_pkg::TAPS_MAX-1:0] active;
		logic [2:0]                   rank;
		logic [2:0]                   mid;
		active = (s1.mode == smf_pkg::MODE_THREE) ? 5'b00111 : 5'b11111;
		mid    = (s1.mode == smf_pkg::MODE_THREE) ? 3'd1 : 3'd2;
		median = '0;
		// ties broken by tap position so exactly one tap holds each rank
		for (int i = 0; i < smf_pkg::TAPS_MAX; i++) begin
			rank = '0;
			for (int j = 0; j < smf_pkg::TAPS_MAX; j++) begin
				if (j != i && active[j] &&
					((s1.win[j] < s1.win[i]) || (s1.win[j] == s1.win[i] && j < i))) begin
					rank = rank + 3'd1;
				end
			end
			if (active[i] && rank == mid) begin
				median = s1.win[i];
			end
		end
	end

endmodule

// ----- hdl/smf_front.sv -----
// smf_front: window history, stream position count and the input register
// depends on smf_pkg, smf_in_if
`timescale 1ns / 1ps

module smf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  smf_pkg::win_mode_t  mode,
	smf_in_if.sink              sample_ch,
	input  logic                take,
	output logic                s1_valid,
	output smf_pkg::s1_t        s1
);

	smf_pkg::sample_t [smf_pkg::HIST_DEPTH-1:0] hist_q;
	smf_pkg::held_t                             held_q;
	logic                                       valid_s1;
	smf_pkg::s1_t                               data_s1;
	logic                                       accept;

	assign sample_ch.ready = !valid_s1 || take;
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign s1_valid        = valid_s1;
	assign s1              = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (sample_ch.last_sample) begin
				hist_q <= '0;
				held_q <= '0;
			end else begin
				hist_q <= {hist_q[smf_pkg::HIST_DEPTH-2:0], sample_ch.sample_in};
				if (held_q < smf_pkg::HELD_MAX) begin
					held_q <= held_q + 3'd1;
				end
			end
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.win  <= {hist_q, sample_ch.sample_in};
			data_s1.held <= held_q;
			data_s1.mode <= mode;
			data_s1.last <= sample_ch.last_sample;
		end
	end

endmodule

// ----- hdl/smf_emit.sv -----
// smf_emit: result register, turns one input item into zero to three beats
// depends on smf_pkg, smf_out_if
`timescale 1ns / 1ps

module smf_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  smf_pkg::s1_t      s1,
	input  smf_pkg::sample_t  median,
	output logic              take,
	smf_out_if.source         result_ch
);

	smf_pkg::beat_cnt_t cnt_q;
	logic               head_q;
	smf_pkg::sample_t   val_q;
	logic               edge_q;
	logic               last_q;

	smf_pkg::held_t     half;
	logic               has_first;
	logic               is_median;
	smf_pkg::beat_cnt_t flush;
	smf_pkg::beat_cnt_t cnt_next;
	logic               pop;

	always_comb begin
		half      = (s1.mode == smf_pkg::MODE_THREE) ? 3'd1 : 3'd2;
		has_first = s1.held >= half;
		is_median = s1.held >= {half[1:0], 1'b0};
		if (!s1.last) begin
			flush = '0;
		end else if (has_first) begin
			flush = half[1:0];
		end else begin
			flush = s1.held[1:0] + 2'd1;
		end
		cnt_next = flush + {1'b0, has_first};
	end

	assign pop  = result_ch.valid && result_ch.ready;
	assign take = s1_valid && (cnt_q == '0 || (cnt_q == 2'd1 && result_ch.ready));

	assign result_ch.valid          = cnt_q != '0;
	assign result_ch.filtered_value = head_q ? val_q : '0;
	assign result_ch.edge_fill      = head_q ? edge_q : 1'b1;
	assign result_ch.last_of_run    = cnt_q == 2'd1;
	assign result_ch.end_of_stream  = cnt_q == 2'd1 && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= 1'b0;
		end else if (take) begin
			cnt_q  <= cnt_next;
			head_q <= 1'b1;
		end else if (pop) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// head beat: true median once the window is full, else an edge zero
			val_q  <= (has_first && is_median) ? median : '0;
			edge_q <= !(has_first && is_median);
			last_q <= s1.last;
		end
	end

endmodule

// ----- tb/sliding_median_filter_tb.sv -----
// sliding_median_filter_tb: self-checking bench for the streaming median filter
// depends on smf_pkg, smf_in_if, smf_out_if and sliding_median_filter from hdl
`timescale 1ns / 1ps

module sliding_median_filter_tb;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 12;
	localparam int IDLE_PCT     = 18;
	localparam int RANDOM_ITEMS = 75;
	// room for the first result plus up to two flush beats, with margin
	localparam int DRAIN_CYCLES = 8;

	// byte addresses on the register port: register index sits in paddr[2]
	localparam logic [smf_pkg::PADDR_BITS-1:0] ADDR_WINDOW_MODE =
		{smf_pkg::REG_WINDOW_MODE, 2'b00};
	localparam logic [smf_pkg::PADDR_BITS-1:0] ADDR_SPARE       =
		{~smf_pkg::REG_WINDOW_MODE, 2'b00};

	// one expected result beat
	typedef struct {
		smf_pkg::sample_t value;
		logic             fill;
		logic             run_end;
		logic             stream_end;
	} median_beat_t;

	// tracks the window state, works out the result beats each sample causes
	// and checks the result channel against them in order
	class median_checker;
		smf_pkg::win_mode_t mode;
		smf_pkg::sample_t   hist[smf_pkg::HIST_DEPTH];
		smf_pkg::held_t     held;
		median_beat_t       expected_medians[$];
		int                 errors;
		int                 samples_seen;
		int                 beats_checked;

		function new();
			mode = smf_pkg::MODE_FIVE;
			foreach (hist[i]) hist[i] = '0;
			held = '0;
			errors = 0;
			samples_seen = 0;
			beats_checked = 0;
		endfunction

		// median of the new sample and the taps-1 newest held samples
		function smf_pkg::sample_t window_median(smf_pkg::sample_t x, int taps);
			smf_pkg::sample_t w[smf_pkg::TAPS_MAX];
			smf_pkg::sample_t t;
			int i;
			int j;
			w[0] = x;
			for (i = 1; i < taps; i++) w[i] = hist[i-1];
			for (i = 1; i < taps; i++) begin
				t = w[i];
				j = i;
				while (j > 0 && w[j-1] > t) begin
					w[j] = w[j-1];
					j--;
				end
				w[j] = t;
			end
			return w[taps/2];
		endfunction

		function void note_sample(smf_pkg::sample_t x, logic last);
			median_beat_t run[$];
			median_beat_t bt;
			int half;
			int k;
			int flush;
			int i;
			samples_seen++;
			half = (mode == smf_pkg::MODE_THREE) ? 1 : 2;
			k = int'(held);
			bt.run_end = 1'b0;
			bt.stream_end = 1'b0;
			// result for the index half a window back
			if (k >= half) begin
				bt.fill = (k < 2*half);
				bt.value = bt.fill ? '0 : window_median(x, 2*half + 1);
				run = {run, bt};
			end
			if (last) begin
				// remaining indices go out as edge zeros, then the window clears
				flush = (k < half) ? k + 1 : half;
				bt.value = '0;
				bt.fill = 1'b1;
				for (i = 0; i < flush; i++) run = {run, bt};
				foreach (hist[n]) hist[n] = '0;
				held = '0;
			end else begin
				for (i = smf_pkg::HIST_DEPTH-1; i > 0; i--) hist[i] = hist[i-1];
				hist[0] = x;
				if (held < smf_pkg::HELD_MAX) held++;
			end
			if (run.size() > 0) begin
				run[run.size()-1].run_end = 1'b1;
				run[run.size()-1].stream_end = last;
			end
			expected_medians = {expected_medians, run};
		endfunction

		function void check_result(smf_pkg::sample_t value, logic fill, logic run_end,
			logic stream_end);
			median_beat_t want;
			if (expected_medians.size() == 0) begin
				$error("result beat with nothing expected: filtered_value %0h", value);
				errors++;
				return;
			end
			want = expected_medians.pop_front();
			beats_checked++;
			if (value !== want.value) begin
				$error("filtered_value: expected %0h, got %0h", want.value, value);
				errors++;
			end
			if (fill !== want.fill) begin
				$error("edge_fill: expected %0b, got %0b", want.fill, fill);
				errors++;
			end
			if (run_end !== want.run_end) begin
				$error("last_of_run: expected %0b, got %0b", want.run_end, run_end);
				errors++;
			end
			if (stream_end !== want.stream_end) begin
				$error("end_of_stream: expected %0b, got %0b", want.stream_end, stream_end);
				errors++;
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [smf_pkg::PADDR_BITS-1:0]    paddr;
	logic [31:0]                       pwdata;
	logic [31:0]                       prdata;
	logic                              pready;

	smf_in_if  sample_ch ();
	smf_out_if result_ch ();

	median_checker sb = new();

	// no random idling on either side while set
	logic steady;
	int   streams_sent;
	int   mode_writes;

	sliding_median_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD/2) clk = ~clk;

	// result side back-pressure: ready drops at random with IDLE_PCT percent odds, never while steady is set
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// every accepted result beat goes straight to the checker
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.filtered_value, result_ch.edge_fill,
				result_ch.last_of_run, result_ch.end_of_stream);
	end

	// hard stop in case a handshake never completes
	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	// setup cycle then access cycle, write lands on the edge with pready high
	task automatic apb_write(input logic [smf_pkg::PADDR_BITS-1:0] addr,
		input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// read back window_mode and compare with what the checker believes
	task automatic check_mode_readback();
		logic [31:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_WINDOW_MODE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {31'b0, sb.mode}) begin
			$error("window_mode: expected %0h, got %0h", {31'b0, sb.mode}, rd);
			sb.errors++;
		end
	endtask

	// upper data bits are junk on purpose, only bit 0 should stick
	task automatic set_window_mode(input smf_pkg::win_mode_t m);
		apb_write(ADDR_WINDOW_MODE, {$urandom} & ~32'h1 | {31'b0, m});
		sb.mode = m;
		mode_writes++;
		check_mode_readback();
	endtask

	// drop valid, wait for every expected beat, then let the pipe settle:
	// a trailing sample with no result may still sit in the input register
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (sb.expected_medians.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one sample beat; valid stays high afterwards unless the next call idles
	task automatic send_sample(input smf_pkg::sample_t s, input logic last);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.sample_in   <= s;
		sample_ch.last_sample <= last;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(s, last);
	endtask

	// mostly random content, with zeros, full scale and near-ties mixed in
	function automatic smf_pkg::sample_t pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return smf_pkg::sample_t'($urandom_range(8));
			default: return smf_pkg::sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int random_items;
		int phase;
		int nstreams;
		int len;
		int i;
		int s;
		smf_pkg::win_mode_t m;

		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		steady    = 1'b0;
		sample_ch.valid       = 1'b0;
		sample_ch.sample_in   = '0;
		sample_ch.last_sample = 1'b0;
		streams_sent = 0;
		mode_writes  = 0;
		random_items = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of window_mode is the five-tap window
		check_mode_readback();

		// five-tap directed streams: one sample, two, four (all edge zeros),
		// six (true medians between the edges), with extreme and toggling values
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		streams_sent += 4;
		wait_drained();

		// a write to the unused register slot must not touch window_mode
		apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
		check_mode_readback();
		set_window_mode(smf_pkg::MODE_THREE);

		// three-tap directed streams: one, two, five samples
		send_sample(16'h0001, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h8000, 1'b1);
		streams_sent += 3;

		// random phases: each starts idle with a fresh mode, sends whole streams,
		// and may leave a stream open so the next mode applies mid-stream
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_drained();
			steady = 1'b0;
			case (phase)
				0: m = smf_pkg::MODE_FIVE;
				1: m = smf_pkg::MODE_THREE;
				default: m = smf_pkg::win_mode_t'($urandom_range(1));
			endcase
			set_window_mode(m);
			if (phase == 1) begin
				apb_write(ADDR_SPARE, {$urandom});
				check_mode_readback();
			end
			// one phase runs with both sides streaming flat out
			steady = (phase == 2);
			nstreams = steady ? 3 : $urandom_range(1, 3);
			for (s = 0; s < nstreams; s++) begin
				len = steady ? $urandom_range(8, 12) : $urandom_range(1, 12);
				for (i = 0; i < len; i++) begin
					send_sample(pick_sample(), i == len - 1);
					random_items++;
				end
				streams_sent++;
				// sender holds off once until the result side is empty
				if (phase == 1 && s == 0) wait_drained();
			end
			// open stream carried into the next phase's mode
			if (phase == 0 || $urandom_range(2) == 0) begin
				len = $urandom_range(1, 5);
				for (i = 0; i < len; i++) begin
					send_sample(pick_sample(), 1'b0);
					random_items++;
				end
			end
			phase++;
		end

		steady = 1'b0;
		wait_drained();

		$display("covered %0d samples over %0d streams, %0d result beats compared",
			sb.samples_seen, streams_sent, sb.beats_checked);
		$display("window_mode written %0d times, both window widths and mid-stream switches",
			mode_writes);
		if (sb.errors == 0 && sb.expected_medians.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/smf_pkg.sv
hdl/smf_in_if.sv
hdl/smf_out_if.sv
hdl/smf_median.sv
hdl/smf_front.sv
hdl/smf_emit.sv
hdl/sliding_median_filter.sv
tb/sliding_median_filter_tb.sv
